[rtl/scht_pkg.sv]
// shared types, codes and constants of the spatial cell hash table
package scht_pkg;

  localparam int BUCKETS_DEF     = 1024;
  localparam int WAYS_DEF        = 4;
  localparam int COORD_BITS_DEF  = 16;
  localparam int HANDLE_BITS_DEF = 16;

  localparam int HASH_KX = 541;
  localparam int HASH_KY = 79;
  localparam int HASH_KZ = 31;

  localparam int MODULUS_W     = 11;
  localparam int MODULUS_RESET = 1024;

  localparam int OUT_HANDLE_W = 16;
  localparam int OUT_DW       = 24;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } scht_op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_RSVD = 2'd3
  } scht_status_t;

  typedef struct packed {
    logic load;
    logic sum;
    logic step;
    logic rd;
    logic commit;
    logic clr;
  } scht_cmd_t;

endpackage

[rtl/scht_ram.sv]
// generic single-port-write ram with registered read
module scht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/scht_ctrl.sv]
// controller: clearing pass, hash/divide sequencing and result handshake
module scht_ctrl
  import scht_pkg::*;
#(
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       out_ready,
  output logic                       out_valid,
  output scht_cmd_t                  cmd,
  output logic [$clog2(BUCKETS)-1:0] clr_addr
);

  localparam int BKT_W = $clog2(BUCKETS);
  localparam int MAG_W = COORD_BITS + 9;
  localparam int CNT_W = $clog2(MAG_W);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SUM   = 6'b000100,
    S_DIV   = 6'b001000,
    S_READ  = 6'b010000,
    S_CMP   = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BKT_W-1:0] clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             res_free;

  assign res_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == BKT_W'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (res_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign clr_addr  = clr_r;

endmodule

[rtl/scht_dp.sv]
// datapath: hash sum, bit-serial modulo, bucket memories and chain update
module scht_dp
  import scht_pkg::*;
#(
  parameter int BUCKETS     = BUCKETS_DEF,
  parameter int WAYS        = WAYS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int IN_DW       = ((2 + 3 * COORD_BITS_DEF + HANDLE_BITS_DEF + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  scht_cmd_t                  cmd,
  input  logic [$clog2(BUCKETS)-1:0] clr_addr,
  input  logic [IN_DW-1:0]           in_data,
  input  logic                       cfg_we,
  input  logic [MODULUS_W-1:0]       cfg_data,
  output logic [OUT_DW-1:0]          out_data
);

  localparam int BKT_W = $clog2(BUCKETS);
  localparam int MOD_W = BKT_W + 1;
  localparam int CW    = (MOD_W > MODULUS_W) ? MOD_W : MODULUS_W;
  localparam int SW    = COORD_BITS + 10;
  localparam int MAG_W = SW - 1;
  localparam int KW    = 3 * COORD_BITS;
  localparam int EW    = KW + HANDLE_BITS;
  localparam int ROW_W = WAYS * EW;
  localparam int FW    = $clog2(WAYS + 1);

  localparam logic signed [SW-1:0] KX = SW'(HASH_KX);
  localparam logic signed [SW-1:0] KY = SW'(HASH_KY);
  localparam logic signed [SW-1:0] KZ = SW'(HASH_KZ);

  logic [MODULUS_W-1:0]   modulus_r;
  scht_op_t               op_r;
  logic [KW-1:0]          key_r;
  logic [HANDLE_BITS-1:0] hnd_r;
  logic [MAG_W-1:0]       mag_r, mag_nxt;
  logic [MOD_W-1:0]       rem_r, rem_nxt;
  logic [MOD_W-1:0]       mod_r, mod_nxt;
  logic                   found_r, found_nxt;
  logic [OUT_HANDLE_W-1:0] fh_r, fh_nxt;
  scht_status_t           st_r, st_nxt;

  logic signed [COORD_BITS-1:0] cx, cy, cz;
  logic signed [SW-1:0]         sum;
  logic [SW-1:0]                sum_abs;
  logic [CW-1:0]                mod_ext;
  logic [MOD_W:0]               rem_sh;
  logic [BKT_W-1:0]             bucket;

  logic [FW-1:0]          fill_q, fill_c, fill_new, hit_idx, fill_wdata;
  logic [ROW_W-1:0]       row_q, row_new;
  logic [ROW_W+EW-1:0]    row_ext;
  logic [WAYS-1:0]        match;
  logic                   hit;
  logic [HANDLE_BITS-1:0] hnd_hit;
  logic                   bucket_full, row_we;
  logic [BKT_W-1:0]       fill_waddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_W'(MODULUS_RESET);
    end else if (cfg_we) begin
      modulus_r <= cfg_data;
    end
  end

  // hash sum and magnitude
  assign cx = $signed(key_r[COORD_BITS-1:0]);
  assign cy = $signed(key_r[2*COORD_BITS-1:COORD_BITS]);
  assign cz = $signed(key_r[3*COORD_BITS-1:2*COORD_BITS]);
  assign sum = SW'(cx) * KX + SW'(cy) * KY + SW'(cz) * KZ;
  assign sum_abs = sum[SW-1] ? SW'(-sum) : SW'(sum);

  // zero acts as one, above the table size acts as the table size
  always_comb begin
    mod_ext = CW'(modulus_r);
    if (mod_ext == '0) begin
      mod_nxt = MOD_W'(1);
    end else if (mod_ext > CW'(BUCKETS)) begin
      mod_nxt = MOD_W'(BUCKETS);
    end else begin
      mod_nxt = MOD_W'(mod_ext);
    end
  end

  // restoring remainder, one dividend bit per cycle
  assign rem_sh = {rem_r, mag_r[MAG_W-1]};
  always_comb begin
    if (rem_sh >= {1'b0, mod_r}) begin
      rem_nxt = MOD_W'(rem_sh - {1'b0, mod_r});
    end else begin
      rem_nxt = MOD_W'(rem_sh);
    end
    mag_nxt = {mag_r[MAG_W-2:0], 1'b0};
  end

  assign bucket = rem_r[BKT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= scht_op_t'(in_data[1:0]);
      key_r <= in_data[2 +: KW];
      hnd_r <= in_data[2 + KW +: HANDLE_BITS];
    end
    if (cmd.sum) begin
      mag_r <= sum_abs[MAG_W-1:0];
      rem_r <= '0;
      mod_r <= mod_nxt;
    end else if (cmd.step) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.commit) begin
      found_r <= found_nxt;
      fh_r    <= fh_nxt;
      st_r    <= st_nxt;
    end
  end

  // compare over the ways of the bucket
  always_comb begin
    fill_c  = (fill_q > FW'(WAYS)) ? FW'(WAYS) : fill_q;
    hit_idx = '0;
    hnd_hit = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = (FW'(w) < fill_c) && (row_q[w*EW +: KW] == key_r);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_idx = FW'(w);
        hnd_hit = row_q[w*EW + KW +: HANDLE_BITS];
      end
    end
    hit = |match;
  end

  assign bucket_full = (fill_c == FW'(WAYS));
  assign row_ext     = {{EW{1'b0}}, row_q};

  always_comb begin
    row_new   = row_q;
    fill_new  = fill_c;
    row_we    = 1'b0;
    found_nxt = 1'b0;
    fh_nxt    = '0;
    st_nxt    = ST_DONE;
    unique case (op_r)
      OP_INSERT: begin
        if (bucket_full) begin
          st_nxt = ST_FULL;
        end else begin
          row_we   = 1'b1;
          fill_new = fill_c + 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (FW'(w) == fill_c) begin
              row_new[w*EW +: EW] = {hnd_r, key_r};
            end
          end
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          row_we    = 1'b1;
          found_nxt = 1'b1;
          fill_new  = fill_c - 1'b1;
          // later entries move down one place
          for (int w = 0; w < WAYS; w++) begin
            if (FW'(w) >= hit_idx) begin
              row_new[w*EW +: EW] = row_ext[(w+1)*EW +: EW];
            end
          end
        end else begin
          st_nxt = ST_MISS;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          found_nxt = 1'b1;
          fh_nxt    = OUT_HANDLE_W'(hnd_hit);
        end else begin
          st_nxt = ST_MISS;
        end
      end
      OP_NONE: begin
        st_nxt = ST_DONE;
      end
      default: begin
        st_nxt = ST_DONE;
      end
    endcase
  end

  assign fill_waddr = cmd.clr ? clr_addr : bucket;
  assign fill_wdata = cmd.clr ? '0 : fill_new;

  scht_ram #(
    .WIDTH (FW),
    .DEPTH (BUCKETS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (cmd.clr || (cmd.commit && row_we)),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (cmd.rd),
    .raddr (bucket),
    .rdata (fill_q)
  );

  scht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (cmd.commit && row_we),
    .waddr (bucket),
    .wdata (row_new),
    .re    (cmd.rd),
    .raddr (bucket),
    .rdata (row_q)
  );

  assign out_data = OUT_DW'({st_r, fh_r, found_r});

endmodule

[rtl/spatial_cell_hash_table_unit.sv]
// a request passes the states sum, divide, read and compare before its result is valid
// one request at a time: the next is taken only after the last is committed; the bit-serial
//   modulo unit finds one remainder bit per cycle
// a finished result waits in the output register while the next request is taken
// reset: synchronous active-low; the bucket fill memory is then cleared,
//   one bucket per cycle over all BUCKETS buckets, before the first request is taken
module spatial_cell_hash_table_unit
  import scht_pkg::*;
#(
  parameter int BUCKETS     = BUCKETS_DEF,
  parameter int WAYS        = WAYS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // op, cell_x, cell_y, cell_z, cell_handle, zero pad
  input  logic [((2 + 3 * COORD_BITS + HANDLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // found, found_handle, status, zero pad
  output logic [OUT_DW-1:0]    out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [MODULUS_W-1:0] cfg_data
);

  localparam int IN_DW = ((2 + 3 * COORD_BITS + HANDLE_BITS + 7) / 8) * 8;

  scht_cmd_t                  cmd;
  logic [$clog2(BUCKETS)-1:0] clr_addr;

  assign cfg_ready = 1'b1;

  scht_ctrl #(
    .BUCKETS    (BUCKETS),
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd),
    .clr_addr  (clr_addr)
  );

  scht_dp #(
    .BUCKETS     (BUCKETS),
    .WAYS        (WAYS),
    .COORD_BITS  (COORD_BITS),
    .HANDLE_BITS (HANDLE_BITS),
    .IN_DW       (IN_DW)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .clr_addr (clr_addr),
    .in_data  (in_tdata),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_tdata)
  );

endmodule

[rtl/scht_chk.sv]
// port-level assertions for the spatial cell hash table
module scht_chk
  import scht_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one request at a time: ready drops after a request
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // a hit always reports done
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[18:17] == ST_DONE)
    else $error("hit with error status");

  // a handle comes only with a hit
  a_handle_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[16:1] == '0)
    else $error("handle without hit");

endmodule

bind spatial_cell_hash_table_unit scht_chk u_scht_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/tb.sv]
// self-checking testbench of the spatial cell hash table unit
`timescale 1ns / 1ps

module tb;
  import scht_pkg::*;

  localparam int IN_DW = ((2 + 3 * 16 + 16 + 7) / 8) * 8;
  localparam int TBL_BUCKETS = 1024;
  localparam int TBL_WAYS = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  // packed from the lowest bit up: op, x, y, z, handle
  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] z;
    logic [15:0] y;
    logic [15:0] x;
    scht_op_t op;
  } cell_req_t;

  // packed from the lowest bit up: found, handle, status
  typedef struct packed {
    scht_status_t status;
    logic [15:0] handle;
    logic found;
  } cell_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MODULUS_W-1:0] cfg_data = '0;

  spatial_cell_hash_table_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [47:0] key_mem [TBL_BUCKETS*TBL_WAYS];
  logic [15:0] handle_mem [TBL_BUCKETS*TBL_WAYS];
  int unsigned chain_len [TBL_BUCKETS];
  logic [MODULUS_W-1:0] modulus = MODULUS_W'(MODULUS_RESET);

  cell_req_t pending_reqs[$];
  cell_resp_t expected_resps[$];
  int errors = 0;
  bit in_took = 1'b0;
  bit long_hold_req = 1'b0;
  int stall_cycles = 0;

  function automatic void queue_req(cell_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic int cell_bucket(cell_req_t r);
    longint s;
    longint mag;
    longint m;
    s = 541 * longint'($signed(r.x)) + 79 * longint'($signed(r.y))
        + 31 * longint'($signed(r.z));
    mag = (s < 0) ? -s : s;
    m = modulus;
    if (m == 0) m = 1;
    if (m > TBL_BUCKETS) m = TBL_BUCKETS;
    return int'(mag % m);
  endfunction

  function automatic cell_resp_t apply_request(cell_req_t r);
    cell_resp_t res;
    int b;
    int base;
    int fill;
    int hit;
    logic [47:0] key;
    res = '{found: 1'b0, handle: 16'd0, status: ST_DONE};
    key = {r.z, r.y, r.x};
    b = cell_bucket(r);
    base = b * TBL_WAYS;
    fill = chain_len[b];
    hit = TBL_WAYS;
    for (int w = fill - 1; w >= 0; w--)
      if (key_mem[base + w] == key) hit = w;
    case (r.op)
      OP_INSERT: begin
        if (fill >= TBL_WAYS) begin
          res.status = ST_FULL;
        end else begin
          key_mem[base + fill] = key;
          handle_mem[base + fill] = r.handle;
          chain_len[b] = fill + 1;
        end
      end
      OP_REMOVE: begin
        if (hit < TBL_WAYS) begin
          for (int w = hit; w + 1 < fill; w++) begin
            key_mem[base + w] = key_mem[base + w + 1];
            handle_mem[base + w] = handle_mem[base + w + 1];
          end
          chain_len[b] = fill - 1;
          res.found = 1'b1;
        end else begin
          res.status = ST_MISS;
        end
      end
      OP_LOOKUP: begin
        if (hit < TBL_WAYS) begin
          res.found = 1'b1;
          res.handle = handle_mem[base + hit];
        end else begin
          res.status = ST_MISS;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // request driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    cell_req_t r;
    if (!in_tvalid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        in_tdata <= {6'd0, r.handle, r.z, r.y, r.x, r.op};
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, stall-free stretches, one long hold-off
  int hold_left = 0;
  int mode_left = 0;
  bit always_ready = 1'b0;
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 200);
      always_ready = $urandom_range(0, 1);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= always_ready || ($urandom_range(0, 3) != 0);
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk) begin
    cell_resp_t got;
    cell_resp_t want;
    cell_req_t r;
    in_took = in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[18:0];
        if (expected_resps.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          want = expected_resps.pop_front();
          if (got.found !== want.found || got.handle !== want.handle ||
              got.status !== want.status) begin
            errors++;
            $display("%0t: mismatch expected found=%0d handle=%h status=%0d,",
                     $time, want.found, want.handle, want.status,
                     " actual found=%0d handle=%h status=%0d",
                     got.found, got.handle, got.status);
          end
        end
      end
      if (in_took) begin
        r = in_tdata[65:0];
        expected_resps.insert(expected_resps.size(), apply_request(r));
      end
      if (cfg_valid && cfg_ready) modulus = cfg_data;
      if ((out_tvalid && out_tready) || in_took || (cfg_valid && cfg_ready) ||
          (pending_reqs.size() == 0 && expected_resps.size() == 0 && !in_tvalid &&
           !cfg_valid)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("spatial_cell_hash_table_unit regression: fail");
          $finish;
        end
      end
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(logic [MODULUS_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic cell_req_t mk(scht_op_t op, int x, int y, int z, int h);
    return '{op: op, x: 16'(x), y: 16'(y), z: 16'(z), handle: 16'(h)};
  endfunction

  // well-formed traffic over a small key set so that chains fill and hit
  task automatic random_phase(int n);
    cell_req_t key_set[24];
    cell_req_t r;
    int p;
    for (int i = 0; i < 24; i++) begin
      key_set[i] = mk(OP_INSERT, $urandom, $urandom, $urandom, 0);
      if ($urandom_range(0, 3) == 0) key_set[i].x = 16'h8000;
      if ($urandom_range(0, 3) == 0) key_set[i].y = 16'h7fff;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) r = key_set[$urandom_range(0, 23)];
      else r = mk(OP_INSERT, $urandom, $urandom, $urandom, 0);
      r.handle = 16'($urandom);
      p = $urandom_range(0, 99);
      if (p < 45) r.op = OP_INSERT;
      else if (p < 70) r.op = OP_REMOVE;
      else if (p < 95) r.op = OP_LOOKUP;
      else r.op = OP_NONE;
      queue_req(r);
    end
  endtask

  initial begin
    for (int b = 0; b < TBL_BUCKETS; b++) chain_len[b] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every op, misses, full bucket, op 3
    queue_req(mk(OP_LOOKUP, 0, 0, 0, 16'hffff));
    queue_req(mk(OP_REMOVE, 0, 0, 0, 0));
    queue_req(mk(OP_INSERT, -32768, -32768, -32768, 16'hffff));
    queue_req(mk(OP_INSERT, 32767, 32767, 32767, 16'h0001));
    queue_req(mk(OP_LOOKUP, -32768, -32768, -32768, 0));
    queue_req(mk(OP_LOOKUP, 32767, 32767, 32767, 0));
    queue_req(mk(OP_NONE, 32767, 32767, 32767, 16'hffff));
    queue_req(mk(OP_REMOVE, 32767, 32767, 32767, 0));
    queue_req(mk(OP_LOOKUP, 32767, 32767, 32767, 0));
    write_modulus(11'd1);
    // single bucket: duplicates, fill past capacity, remove from the middle
    for (int i = 0; i < 5; i++) queue_req(mk(OP_INSERT, 3, -4, i % 2, 16'h100 + i));
    queue_req(mk(OP_REMOVE, 3, -4, 1, 0));
    queue_req(mk(OP_LOOKUP, 3, -4, 1, 0));
    queue_req(mk(OP_LOOKUP, 3, -4, 0, 0));
    queue_req(mk(OP_INSERT, 9, 9, 9, 16'h5a5a));
    queue_req(mk(OP_LOOKUP, 9, 9, 9, 0));
    write_modulus(11'd0);
    queue_req(mk(OP_LOOKUP, 9, 9, 9, 0));
    write_modulus(11'd2047);
    queue_req(mk(OP_LOOKUP, -32768, -32768, -32768, 0));
    queue_req(mk(OP_INSERT, 1, 2, 3, 16'h1234));

    random_phase(300);
    long_hold_req = 1'b1;
    write_modulus(11'd1);
    random_phase(250);
    write_modulus(11'($urandom_range(2, 17)));
    random_phase(300);
    write_modulus(11'd1024);
    random_phase(300);
    write_modulus(11'd0);
    random_phase(150);
    write_modulus(11'($urandom_range(18, 1023)));
    random_phase(250);
    write_modulus(11'($urandom_range(1025, 2047)));
    random_phase(130);
    wait_idle();

    if (errors == 0) begin
      $display("spatial_cell_hash_table_unit regression: pass");
    end else begin
      $display("spatial_cell_hash_table_unit regression: fail");
    end
    $finish;
  end

endmodule
